[hw/rtl/stuffed_frame_receiver_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the stuffed frame receiver
// Clocked property checks, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef STUFFED_FRAME_RECEIVER_ASSERT_SVH
`define STUFFED_FRAME_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
`define SFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SFR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SFR_ASSERT(label, prop, msg)
`define SFR_ASSERT_RST(label, prop, msg)
`endif
`endif

[hw/rtl/sfr_pkg.sv]
// ---------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the stuffed frame receiver modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package sfr_pkg;

  localparam logic [7:0] CTL_SOH = 8'h01;
  localparam logic [7:0] CTL_EOT = 8'h04;
  localparam logic [7:0] CTL_ACK = 8'h06;
  localparam logic [7:0] CTL_NAK = 8'h15;
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_NINE = 8'd57;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_UPPER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_UPPER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIT_UPPER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_LOWER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_LOWER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIT_LOWER = 3'd5;

  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_SHORT    = 2'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_LVL_W = 3;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_UPPER = 2'd1,
    ESC_LOWER = 2'd2
  } esc_t;

  typedef struct packed {
    logic [7:0] esc_upper;
    logic [7:0] tag_upper;
    logic [7:0] lit_upper;
    logic [7:0] esc_lower;
    logic [7:0] tag_lower;
    logic [7:0] lit_lower;
  } cfg_t;

  typedef struct packed {
    logic       clear;
    logic       eot;
    logic       p0_v;
    logic [7:0] p0;
    logic       p1_v;
    logic [7:0] p1;
  } push_plan_t;

  typedef struct packed {
    logic [7:0] payload;
    logic       valid;
    logic       frame_end;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic r0_v;
    res_t r0;
    logic r1_v;
    res_t r1;
  } res_pair_t;

  typedef struct packed {
    logic [FIFO_LVL_W-1:0] level;
    logic                  room;
  } fifo_stat_t;

endpackage

[hw/rtl/sfr_unstuff.sv]
// ---------------------------------------------------------------------------
// sfr_unstuff
// Frame tracking and escape removal; turns one line byte into up to two
// unstuffed bytes plus clear and end-of-frame flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sfr_unstuff (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  input  sfr_pkg::cfg_t       cfg,
  output sfr_pkg::push_plan_t plan
);
  import sfr_pkg::*;

  logic in_frame_r, in_frame_nxt;
  esc_t esc_r, esc_nxt;
  logic take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= ESC_NONE;
    end else if (fire) begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
    end
  end

  always_comb begin
    plan         = '0;
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    take         = 1'b0;
    priority if (rx_byte == CTL_ACK || rx_byte == CTL_NAK) begin
    end else if (rx_byte == CTL_SOH) begin
      plan.clear   = 1'b1;
      plan.p0_v    = 1'b1;
      plan.p0      = CTL_SOH;
      in_frame_nxt = 1'b1;
      esc_nxt      = ESC_NONE;
    end else if (!in_frame_r) begin
    end else if (rx_byte == CTL_EOT) begin
      unique case (esc_r)
        ESC_UPPER: begin
          plan.p0_v = 1'b1;
          plan.p0   = cfg.esc_upper;
        end
        ESC_LOWER: begin
          plan.p0_v = 1'b1;
          plan.p0   = cfg.esc_lower;
        end
        default: ;
      endcase
      plan.eot     = 1'b1;
      in_frame_nxt = 1'b0;
      esc_nxt      = ESC_NONE;
    end else begin
      take    = 1'b1;
      esc_nxt = ESC_NONE;
      unique case (esc_r)
        ESC_UPPER: begin
          plan.p0_v = 1'b1;
          if (rx_byte == cfg.tag_upper) begin
            plan.p0 = cfg.lit_upper;
            take    = 1'b0;
          end else begin
            plan.p0 = cfg.esc_upper;
            take    = (rx_byte != cfg.esc_upper);
          end
        end
        ESC_LOWER: begin
          plan.p0_v = 1'b1;
          if (rx_byte == cfg.tag_lower) begin
            plan.p0 = cfg.lit_lower;
            take    = 1'b0;
          end else begin
            plan.p0 = cfg.esc_lower;
            take    = (rx_byte != cfg.esc_lower);
          end
        end
        default: ;
      endcase
      if (take) begin
        priority if (rx_byte == cfg.esc_upper) begin
          esc_nxt = ESC_UPPER;
        end else if (rx_byte == cfg.esc_lower) begin
          esc_nxt = ESC_LOWER;
        end else if (plan.p0_v) begin
          plan.p1_v = 1'b1;
          plan.p1   = rx_byte;
        end else begin
          plan.p0_v = 1'b1;
          plan.p0   = rx_byte;
        end
      end
    end
  end

endmodule

[hw/rtl/sfr_track.sv]
// ---------------------------------------------------------------------------
// sfr_track
// Checksum digit delay line, running sum, held payload byte and verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sfr_track #(
  parameter int HEADER_BYTES    = 7,
  parameter int CHECKSUM_DIGITS = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  sfr_pkg::push_plan_t plan,
  output sfr_pkg::res_pair_t  res
);
  import sfr_pkg::*;

  localparam int CNT_W = 16;
  localparam int VAL_W = 17;
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_DIG   = CNT_W'(CHECKSUM_DIGITS);
  localparam logic [CNT_W-1:0] CNT_FRAME = CNT_W'(HEADER_BYTES + CHECKSUM_DIGITS);

  typedef struct packed {
    logic [CNT_W-1:0]                 cnt;
    logic [7:0]                       sum;
    logic [7:0]                       held;
    logic                             held_v;
    logic [CHECKSUM_DIGITS-1:0][7:0]  dd;
  } trk_t;

  typedef struct packed {
    trk_t       st;
    logic       emit;
    logic [7:0] emit_byte;
  } push_t;

  function automatic push_t push(input trk_t s, input logic [7:0] v);
    push_t r;
    r           = '0;
    r.st        = s;
    r.emit_byte = s.held;
    if (s.cnt >= CNT_DIG) begin
      r.st.sum = s.sum + s.dd[CHECKSUM_DIGITS-1];
    end
    if (s.cnt >= CNT_FRAME) begin
      r.emit      = s.held_v;
      r.st.held   = s.dd[CHECKSUM_DIGITS-1];
      r.st.held_v = 1'b1;
    end
    for (int i = CHECKSUM_DIGITS - 1; i > 0; i--) begin
      r.st.dd[i] = s.dd[i-1];
    end
    r.st.dd[0] = v;
    if (s.cnt != CNT_MAX) begin
      r.st.cnt = s.cnt + 1'b1;
    end
    return r;
  endfunction

  trk_t       st_r, st_nxt, base, s1, s2;
  push_t      u0, u1;
  logic [1:0] status;
  logic       digits_ok;
  logic [VAL_W-1:0] value, weight;
  logic [7:0] dig;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.cnt    <= '0;
      st_r.sum    <= '0;
      st_r.held_v <= 1'b0;
    end else if (fire) begin
      st_r.cnt    <= st_nxt.cnt;
      st_r.sum    <= st_nxt.sum;
      st_r.held_v <= st_nxt.held_v;
      st_r.held   <= st_nxt.held;
      st_r.dd     <= st_nxt.dd;
    end
  end

  always_comb begin
    base = st_r;
    if (plan.clear) begin
      base.cnt    = '0;
      base.sum    = '0;
      base.held_v = 1'b0;
    end
    u0 = push(base, plan.p0);
    s1 = plan.p0_v ? u0.st : base;
    u1 = push(s1, plan.p1);
    s2 = plan.p1_v ? u1.st : s1;
  end

  always_comb begin
    value     = '0;
    weight    = VAL_W'(1);
    digits_ok = 1'b1;
    dig       = '0;
    for (int i = 0; i < CHECKSUM_DIGITS; i++) begin
      dig = s2.dd[i] - ASCII_ZERO;
      if (s2.dd[i] < ASCII_ZERO || s2.dd[i] > ASCII_NINE) begin
        digits_ok = 1'b0;
      end
      value  = value + VAL_W'({{(VAL_W-4){1'b0}}, dig[3:0]} * weight);
      weight = VAL_W'(weight * VAL_W'(10));
    end
    priority if (s2.cnt < CNT_FRAME) begin
      status = STATUS_SHORT;
    end else if (!digits_ok || value != {{(VAL_W-8){1'b0}}, s2.sum}) begin
      status = STATUS_MISMATCH;
    end else begin
      status = STATUS_GOOD;
    end
  end

  always_comb begin
    st_nxt = s2;
    if (plan.eot) begin
      st_nxt.cnt    = '0;
      st_nxt.sum    = '0;
      st_nxt.held_v = 1'b0;
    end
    res            = '0;
    res.r0_v       = fire && plan.p0_v && u0.emit;
    res.r0.payload = u0.emit_byte;
    res.r0.valid   = 1'b1;
    if (plan.eot) begin
      res.r1_v         = fire;
      res.r1.payload   = s2.held_v ? s2.held : 8'd0;
      res.r1.valid     = s2.held_v;
      res.r1.frame_end = 1'b1;
      res.r1.status    = status;
    end else begin
      res.r1_v       = fire && plan.p1_v && u1.emit;
      res.r1.payload = u1.emit_byte;
      res.r1.valid   = 1'b1;
    end
  end

endmodule

[hw/rtl/sfr_out_fifo.sv]
// ---------------------------------------------------------------------------
// sfr_out_fifo
// Result queue; takes up to two results a cycle, delivers one per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sfr_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfr_pkg::res_pair_t   wr,
  input  logic                 rd,
  output sfr_pkg::res_t        head,
  output logic                 not_empty,
  output sfr_pkg::fifo_stat_t  stat
);
  import sfr_pkg::*;

  res_t mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r, rp_r;
  logic [FIFO_LVL_W-1:0] lvl_r;
  logic [1:0] wr_n;
  res_t first;

  assign wr_n  = {1'b0, wr.r0_v} + {1'b0, wr.r1_v};
  assign first = wr.r0_v ? wr.r0 : wr.r1;

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      mem_r[wp_r] <= first;
    end
    if (wr_n == 2'd2) begin
      mem_r[wp_r + 1'b1] <= wr.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      wp_r  <= wp_r + FIFO_PTR_W'(wr_n);
      rp_r  <= rp_r + FIFO_PTR_W'(rd);
      lvl_r <= lvl_r + FIFO_LVL_W'(wr_n) - FIFO_LVL_W'(rd);
    end
  end

  assign head       = mem_r[rp_r];
  assign not_empty  = (lvl_r != '0);
  assign stat.level = lvl_r;
  assign stat.room  = (lvl_r <= FIFO_LVL_W'(FIFO_DEPTH - 2));

endmodule

[hw/rtl/stuffed_frame_receiver.sv]
// ---------------------------------------------------------------------------
// stuffed_frame_receiver
// Deframer for byte-stuffed serial frames with an ASCII decimal sum check.
//
//   port group  | dir    | handshake           | carries
//   in_*        | input  | in_valid / in_stall | in_rx_byte
//   out_*       | output | out_valid/out_stall | payload byte, valid, end, status
//   cfg_*       | input  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One line byte is taken per cycle while in_stall is low; its results are
// written into the output queue by the edge that accepts it.
// A byte giving two results takes an output beat for each; the four-entry queue
// stalls the input once it cannot hold two more results.
// Synchronous active-low reset clears frame state and the queue.
// cfg_ready is always high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stuffed_frame_receiver_assert.svh"
module stuffed_frame_receiver #(
  parameter int HEADER_BYTES    = 7,
  parameter int CHECKSUM_DIGITS = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_payload_byte,
  output logic                          out_byte_valid,
  output logic                          out_frame_end,
  output logic [1:0]                    out_frame_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import sfr_pkg::*;

  cfg_t       cfg_r;
  push_plan_t plan;
  res_pair_t  res;
  res_t       head;
  fifo_stat_t fstat;
  logic       in_fire, out_fire;
  logic       bare_clean;

  assign cfg_ready = 1'b1;
  assign in_stall  = !fstat.room;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.esc_upper <= 8'd69;
      cfg_r.tag_upper <= 8'd88;
      cfg_r.lit_upper <= 8'd68;
      cfg_r.esc_lower <= 8'd101;
      cfg_r.tag_lower <= 8'd120;
      cfg_r.lit_lower <= 8'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ESC_UPPER: cfg_r.esc_upper <= cfg_data;
        CFG_TAG_UPPER: cfg_r.tag_upper <= cfg_data;
        CFG_LIT_UPPER: cfg_r.lit_upper <= cfg_data;
        CFG_ESC_LOWER: cfg_r.esc_lower <= cfg_data;
        CFG_TAG_LOWER: cfg_r.tag_lower <= cfg_data;
        CFG_LIT_LOWER: cfg_r.lit_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  sfr_unstuff u_unstuff (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .plan    (plan)
  );

  sfr_track #(
    .HEADER_BYTES    (HEADER_BYTES),
    .CHECKSUM_DIGITS (CHECKSUM_DIGITS)
  ) u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .plan  (plan),
    .res   (res)
  );

  sfr_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (res),
    .rd        (out_fire),
    .head      (head),
    .not_empty (out_valid),
    .stat      (fstat)
  );

  assign out_payload_byte = head.payload;
  assign out_byte_valid   = head.valid;
  assign out_frame_end    = head.frame_end;
  assign out_frame_status = head.status;

  assign bare_clean = (out_payload_byte == 8'd0) && out_frame_end;

  `SFR_ASSERT(a_level_bound, fstat.level <= FIFO_LVL_W'(FIFO_DEPTH), "result queue overflow")
  `SFR_ASSERT(a_empty_takes, !out_valid |-> !in_stall, "input stalled with empty queue")
  `SFR_ASSERT(a_void_zero, (out_valid && !out_byte_valid) |-> bare_clean, "bad bare frame end")
  `SFR_ASSERT_RST(a_reset_empty, (rst_n && $past(!rst_n)) |-> !out_valid, "results after reset")

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the stuffed frame receiver. Frames are built with
// escape stuffing and ASCII decimal sums under several escape settings, mixed
// with line noise, ACK/NAK bytes, restarts and broken frames. A clocked
// driver offers line bytes with random gaps and a clocked monitor stalls at
// random; every accepted byte is run through a local deframer model and each
// output beat is compared field by field against the oldest expected result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import sfr_pkg::*;

  localparam int PERIOD       = 4;
  localparam int HDR          = 7;
  localparam int DIGITS       = 5;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_TICKS = 8;
  localparam int LONG_PAYLOAD = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

  localparam logic [7:0] DEF_ESC_UPPER = 8'h45;
  localparam logic [7:0] DEF_TAG_UPPER = 8'h58;
  localparam logic [7:0] DEF_LIT_UPPER = 8'h44;
  localparam logic [7:0] DEF_ESC_LOWER = 8'h65;
  localparam logic [7:0] DEF_TAG_LOWER = 8'h78;
  localparam logic [7:0] DEF_LIT_LOWER = 8'h64;
  localparam logic [7:0] PLAIN_BYTE    = 8'h71;

  typedef logic [7:0] byte_q_t [$];

  typedef enum int {
    FRM_GOOD,
    FRM_BAD_SUM,
    FRM_BAD_DIGIT
  } frame_kind_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;
  } reg_write_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [7:0]           out_payload_byte;
  logic                 out_byte_valid;
  logic                 out_frame_end;
  logic [1:0]           out_frame_status;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [7:0]           cfg_data   = 8'h00;

  stuffed_frame_receiver #(
    .HEADER_BYTES    (HDR),
    .CHECKSUM_DIGITS (DIGITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_byte_valid   (out_byte_valid),
    .out_frame_end    (out_frame_end),
    .out_frame_status (out_frame_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  // deframer model state
  cfg_t       esc_regs;
  logic       m_in_frame  = 1'b0;
  esc_t       m_esc       = ESC_NONE;
  logic [7:0] m_tail [DIGITS];
  logic [7:0] m_hold_byte = 8'h00;
  logic       m_hold_ok   = 1'b0;
  logic [15:0] m_count    = 16'd0;
  logic [7:0] m_sum       = 8'h00;

  res_t       expected_results [$];
  logic [7:0] tx_q [$];
  reg_write_t reg_writes [$];

  bit         idle_on    = 1'b1;
  bit         ack_noise  = 1'b0;
  bit         hold_go    = 1'b0;
  logic       rx_hold    = 1'b0;
  int         hold_count = 0;
  int         gap_left   = 0;
  int         stall_left = 0;
  int         cycle_count;
  int         fail_count     = 0;
  int         results_seen   = 0;
  int         bytes_queued   = 0;
  int         frames_built   = 0;
  int         settings_used  = 0;
  logic [7:0] frame_sum;
  res_t       want;

  // ---- deframer model ----------------------------------------------------

  function automatic void expect_result(logic [7:0] v, logic ok, logic last, logic [1:0] st);
    expected_results.insert(expected_results.size(),
                            res_t'{payload: v, valid: ok, frame_end: last, status: st});
  endfunction

  function automatic void clear_model_frame();
    m_esc       = ESC_NONE;
    m_hold_ok   = 1'b0;
    m_hold_byte = 8'h00;
    m_count     = 16'd0;
    m_sum       = 8'h00;
    foreach (m_tail[i]) m_tail[i] = 8'h00;
  endfunction

  function automatic void unstuffed_push(logic [7:0] v);
    logic [7:0] leaving;
    if (m_count >= DIGITS) begin
      leaving = m_tail[DIGITS-1];
      m_sum   = m_sum + leaving;
      if (int'(m_count) - DIGITS >= HDR) begin
        if (m_hold_ok) expect_result(m_hold_byte, 1'b1, 1'b0, STATUS_GOOD);
        m_hold_byte = leaving;
        m_hold_ok   = 1'b1;
      end
    end
    for (int i = DIGITS - 1; i > 0; i--) m_tail[i] = m_tail[i-1];
    m_tail[0] = v;
    if (m_count != 16'hFFFF) m_count = m_count + 16'd1;
  endfunction

  function automatic logic [1:0] frame_verdict();
    int         value;
    int         weight;
    bit         digits_ok;
    logic [7:0] c;
    if (int'(m_count) < HDR + DIGITS) return STATUS_SHORT;
    value     = 0;
    weight    = 1;
    digits_ok = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      c = m_tail[i];
      if (c < ASCII_ZERO || c > ASCII_NINE) digits_ok = 1'b0;
      else value += int'(c - ASCII_ZERO) * weight;
      weight *= 10;
    end
    if (!digits_ok || value != int'(m_sum)) return STATUS_MISMATCH;
    return STATUS_GOOD;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [1:0] st;
    if (b == CTL_ACK || b == CTL_NAK) return;
    if (b == CTL_SOH) begin
      clear_model_frame();
      m_in_frame = 1'b1;
      unstuffed_push(CTL_SOH);
      return;
    end
    if (!m_in_frame) return;
    if (b == CTL_EOT) begin
      if (m_esc == ESC_UPPER) unstuffed_push(esc_regs.esc_upper);
      else if (m_esc == ESC_LOWER) unstuffed_push(esc_regs.esc_lower);
      m_esc = ESC_NONE;
      st = frame_verdict();
      if (m_hold_ok) expect_result(m_hold_byte, 1'b1, 1'b1, st);
      else expect_result(8'h00, 1'b0, 1'b1, st);
      m_in_frame = 1'b0;
      clear_model_frame();
      return;
    end
    if (m_esc == ESC_UPPER) begin
      m_esc = ESC_NONE;
      if (b == esc_regs.tag_upper) begin
        unstuffed_push(esc_regs.lit_upper);
        return;
      end
      unstuffed_push(esc_regs.esc_upper);
      if (b == esc_regs.esc_upper) return;
    end else if (m_esc == ESC_LOWER) begin
      m_esc = ESC_NONE;
      if (b == esc_regs.tag_lower) begin
        unstuffed_push(esc_regs.lit_lower);
        return;
      end
      unstuffed_push(esc_regs.esc_lower);
      if (b == esc_regs.esc_lower) return;
    end
    if (b == esc_regs.esc_upper) m_esc = ESC_UPPER;
    else if (b == esc_regs.esc_lower) m_esc = ESC_LOWER;
    else unstuffed_push(b);
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] d);
    case (idx)
      CFG_ESC_UPPER: esc_regs.esc_upper = d;
      CFG_TAG_UPPER: esc_regs.tag_upper = d;
      CFG_LIT_UPPER: esc_regs.lit_upper = d;
      CFG_ESC_LOWER: esc_regs.esc_lower = d;
      CFG_TAG_LOWER: esc_regs.tag_lower = d;
      CFG_LIT_LOWER: esc_regs.lit_lower = d;
      default: ;
    endcase
  endfunction

  // ---- frame building ----------------------------------------------------

  function automatic bit is_ctl(logic [7:0] v);
    return v == CTL_SOH || v == CTL_EOT || v == CTL_ACK || v == CTL_NAK;
  endfunction

  function automatic void send_line(logic [7:0] b);
    if (ack_noise && $urandom_range(0, 39) == 0) begin
      tx_q.insert(tx_q.size(), $urandom_range(0, 1) ? CTL_ACK : CTL_NAK);
      bytes_queued++;
    end
    tx_q.insert(tx_q.size(), b);
    bytes_queued++;
  endfunction

  function automatic bit try_stuff(logic [7:0] v, bit use_esc);
    logic [7:0] eu, tu, el, tl;
    eu = esc_regs.esc_upper;
    tu = esc_regs.tag_upper;
    el = esc_regs.esc_lower;
    tl = esc_regs.tag_lower;
    if (use_esc || is_ctl(v) || v == eu || v == el) begin
      if (v == esc_regs.lit_upper && !is_ctl(eu) && !is_ctl(tu)) begin
        send_line(eu);
        send_line(tu);
        return 1'b1;
      end
      if (v == esc_regs.lit_lower && el != eu && !is_ctl(el) && !is_ctl(tl)) begin
        send_line(el);
        send_line(tl);
        return 1'b1;
      end
      if (v == eu && tu != eu && !is_ctl(v)) begin
        send_line(eu);
        send_line(eu);
        return 1'b1;
      end
      if (v == el && el != eu && tl != el && !is_ctl(v)) begin
        send_line(el);
        send_line(el);
        return 1'b1;
      end
    end
    if (is_ctl(v) || v == eu || v == el) return 1'b0;
    send_line(v);
    return 1'b1;
  endfunction

  // values that cannot be stuffed under this setting are replaced
  function automatic void put_byte(logic [7:0] v, bit use_esc);
    while (!try_stuff(v, use_esc)) v = 8'($urandom_range(0, 255));
    frame_sum = frame_sum + v;
  endfunction

  // escape followed by a byte that is neither its tag nor an escape
  function automatic void put_lone_escape(bit lower);
    logic [7:0] e, t, p;
    e = lower ? esc_regs.esc_lower : esc_regs.esc_upper;
    t = lower ? esc_regs.tag_lower : esc_regs.tag_upper;
    if (is_ctl(e) || (lower && esc_regs.esc_lower == esc_regs.esc_upper)) return;
    do p = 8'($urandom_range(0, 255));
    while (is_ctl(p) || p == t || p == esc_regs.esc_upper || p == esc_regs.esc_lower);
    send_line(e);
    send_line(p);
    frame_sum = frame_sum + e + p;
  endfunction

  function automatic void put_content(logic [7:0] v);
    if ($urandom_range(0, 29) == 0) put_lone_escape(1'($urandom_range(0, 1)));
    put_byte(v, $urandom_range(0, 3) == 0);
  endfunction

  function automatic logic [7:0] pick_value();
    case ($urandom_range(0, 9))
      0: return esc_regs.esc_upper;
      1: return esc_regs.esc_lower;
      2: return esc_regs.lit_upper;
      3: return esc_regs.lit_lower;
      4: return esc_regs.tag_upper;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic build_frame(input byte_q_t payload, input frame_kind_t kind);
    int         value;
    int         bad_pos;
    logic [7:0] dig [DIGITS];
    frames_built++;
    frame_sum = CTL_SOH;
    send_line(CTL_SOH);
    repeat (HDR - 1) put_content(8'($urandom_range(0, 255)));
    foreach (payload[i]) put_content(payload[i]);
    value = int'(frame_sum);
    if (kind == FRM_BAD_SUM) begin
      if ($urandom_range(0, 1)) value = (value + $urandom_range(1, 255)) % 256;
      else value = $urandom_range(256, 99999);
    end
    for (int i = 0; i < DIGITS; i++) begin
      dig[i] = ASCII_ZERO + 8'(value % 10);
      value  = value / 10;
    end
    if (kind == FRM_BAD_DIGIT) begin
      bad_pos = $urandom_range(0, DIGITS - 1);
      do dig[bad_pos] = 8'($urandom_range(0, 255));
      while (dig[bad_pos] >= ASCII_ZERO && dig[bad_pos] <= ASCII_NINE);
    end
    for (int i = DIGITS - 1; i >= 0; i--) put_byte(dig[i], $urandom_range(0, 3) == 0);
    send_line(CTL_EOT);
  endtask

  task automatic short_frame(input int k);
    frames_built++;
    send_line(CTL_SOH);
    repeat (k) put_content(pick_value());
    if ($urandom_range(0, 2) == 0 && !is_ctl(esc_regs.esc_upper))
      send_line(esc_regs.esc_upper);
    send_line(CTL_EOT);
  endtask

  task automatic noise_frame(input int k);
    logic [7:0] v;
    frames_built++;
    send_line(CTL_SOH);
    repeat (k) begin
      v = $urandom_range(0, 1) ? pick_value() : 8'($urandom_range(0, 255));
      if (v != CTL_SOH) send_line(v);
    end
    send_line(CTL_EOT);
  endtask

  task automatic random_traffic(input int n_items);
    int         start;
    int         sel;
    int         len;
    logic [7:0] v;
    byte_q_t    pl;
    start = bytes_queued;
    while (bytes_queued - start < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          do v = 8'($urandom_range(0, 255));
          while (v == CTL_SOH);
          send_line(v);
        end
      end
      pl.delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      repeat (len) pl.insert(pl.size(), pick_value());
      sel = $urandom_range(0, 99);
      if (sel < 55) build_frame(pl, FRM_GOOD);
      else if (sel < 67) build_frame(pl, FRM_BAD_SUM);
      else if (sel < 75) build_frame(pl, FRM_BAD_DIGIT);
      else if (sel < 85) short_frame($urandom_range(0, 10));
      else if (sel < 93) noise_frame($urandom_range(0, 20));
      else begin
        // abandoned frame, restarted by the next SOH
        frames_built++;
        send_line(CTL_SOH);
        repeat ($urandom_range(0, 8)) put_content(pick_value());
        build_frame(pl, FRM_GOOD);
      end
    end
  endtask

  // ---- sequencing helpers ------------------------------------------------

  task automatic settle();
    while (tx_q.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] eu, tu, lu, el, tl, ll);
    reg_writes.insert(reg_writes.size(), reg_write_t'{CFG_ESC_UPPER, eu});
    reg_writes.insert(reg_writes.size(), reg_write_t'{CFG_TAG_UPPER, tu});
    reg_writes.insert(reg_writes.size(), reg_write_t'{CFG_LIT_UPPER, lu});
    reg_writes.insert(reg_writes.size(), reg_write_t'{CFG_ESC_LOWER, el});
    reg_writes.insert(reg_writes.size(), reg_write_t'{CFG_TAG_LOWER, tl});
    reg_writes.insert(reg_writes.size(), reg_write_t'{CFG_LIT_LOWER, ll});
    while (reg_writes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    settings_used++;
  endtask

  task automatic directed_frames();
    byte_q_t pl;
    send_line(CTL_EOT);
    send_line(CTL_ACK);
    send_line(8'hFF);
    // short frame with literal, doubled and lone escapes, escape left at EOT
    frames_built++;
    send_line(CTL_SOH);
    send_line(esc_regs.esc_upper);
    send_line(esc_regs.tag_upper);
    send_line(esc_regs.esc_lower);
    send_line(esc_regs.esc_lower);
    send_line(esc_regs.esc_upper);
    send_line(PLAIN_BYTE);
    send_line(esc_regs.esc_lower);
    send_line(CTL_EOT);
    // partial frame restarted by a good one with extreme payload bytes
    frames_built++;
    send_line(CTL_SOH);
    send_line(esc_regs.tag_lower);
    pl.insert(pl.size(), 8'h00);
    pl.insert(pl.size(), 8'hFF);
    build_frame(pl, FRM_GOOD);
  endtask

  // ---- driver ------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_rx_byte);
        void'(tx_q.pop_front());
        gap_left = pick_gap();
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (tx_q.size() != 0) begin
          in_valid   <= 1'b1;
          in_rx_byte <= tx_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        void'(reg_writes.pop_front());
      end
      if (!(cfg_valid && !cfg_ready)) begin
        if (reg_writes.size() != 0) begin
          cfg_valid <= 1'b1;
          cfg_index <= reg_writes[0].index;
          cfg_data  <= reg_writes[0].data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver hold-off and monitor -------------------------------------

  always @(posedge clk) begin
    if (hold_go && hold_count < HOLD_CYCLES) begin
      rx_hold    <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected beat: payload_byte %0h byte_valid %0b frame_end %0b status %0d",
                 out_payload_byte, out_byte_valid, out_frame_end, out_frame_status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          results_seen++;
          if (out_payload_byte !== want.payload) begin
            $error("payload_byte: expected %0h, got %0h", want.payload, out_payload_byte);
            fail_count++;
          end
          if (out_byte_valid !== want.valid) begin
            $error("byte_valid: expected %0b, got %0b", want.valid, out_byte_valid);
            fail_count++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, out_frame_end);
            fail_count++;
          end
          if (out_frame_status !== want.status) begin
            $error("frame_status: expected %0d, got %0d", want.status, out_frame_status);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 3) == 0)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_stall <= rx_hold || (stall_left > 0);
    end
  end

  // ---- run control -------------------------------------------------------

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $error("run did not complete within %0d cycles", CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    byte_q_t big;
    esc_regs = '{DEF_ESC_UPPER, DEF_TAG_UPPER, DEF_LIT_UPPER,
                 DEF_ESC_LOWER, DEF_TAG_LOWER, DEF_LIT_LOWER};
    foreach (m_tail[i]) m_tail[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings: directed frames, then traffic through a long hold-off
    settings_used++;
    directed_frames();
    settle();
    ack_noise = 1'b1;
    hold_go   = 1'b1;
    random_traffic(250);
    settle();

    program_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    reg_writes.insert(reg_writes.size(), reg_write_t'{CFG_IDX_SPARE_A, 8'hA5});
    reg_writes.insert(reg_writes.size(), reg_write_t'{CFG_IDX_SPARE_B, 8'h5A});
    while (reg_writes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    random_traffic(100);
    settle();

    program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    random_traffic(100);
    settle();

    // shared escape, tag equal to escape, literals that are control bytes
    program_regs(8'h5A, 8'h5A, CTL_SOH, 8'h5A, 8'h7E, CTL_EOT);
    random_traffic(100);
    settle();

    // escape equal to SOH, lower escape and lower tag among the digits
    program_regs(CTL_SOH, DEF_TAG_UPPER, DEF_LIT_UPPER, 8'h37, 8'h38, 8'h33);
    random_traffic(100);
    settle();

    repeat (3) begin
      program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_traffic(90);
      settle();
    end

    // back to defaults, no idling: a longer frame and traffic at full rate
    program_regs(DEF_ESC_UPPER, DEF_TAG_UPPER, DEF_LIT_UPPER,
                 DEF_ESC_LOWER, DEF_TAG_LOWER, DEF_LIT_LOWER);
    idle_on   = 1'b0;
    ack_noise = 1'b0;
    repeat (LONG_PAYLOAD) big.insert(big.size(), 8'($urandom_range(0, 255)));
    build_frame(big, FRM_GOOD);
    random_traffic(40);
    settle();
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("Run covered %0d frames in %0d line bytes under %0d escape settings.",
             frames_built, bytes_queued, settings_used);
    $display("%0d output beats compared, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
